[src/spring_damper_impulse_core_defines.svh]
// Assertion macros shared by the spring damper impulse core.
`ifndef SPRING_DAMPER_IMPULSE_CORE_DEFINES_SVH
`define SPRING_DAMPER_IMPULSE_CORE_DEFINES_SVH

// Clocked assertion with explicit clock and active-low reset.
`define SDI_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the core clock and reset.
`define SDI_ASSERT(lbl, prop, msg) \
  `SDI_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[src/sdi_pkg.sv]
// ----------------------------------------------------------------------------
// sdi_pkg
// Types, constants and fixed-point helpers of the spring damper impulse core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdi_pkg;

  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int DIR_BITS     = 30;
  localparam int REG_BITS     = 31;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int QDEPTH       = 4;
  localparam int QPTR_BITS    = $clog2(QDEPTH);

  localparam logic [REG_BITS-1:0] STEP_RESET    = 31'd1092;
  localparam logic [REG_BITS-1:0] CEILING_RESET = 31'd65536000;

  localparam logic [CFG_IDX_BITS-1:0] REG_STIFF = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DAMP  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_NAT   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CEIL  = 3'd4;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] end_a_x;
    logic signed [WORD_BITS-1:0] end_a_y;
    logic signed [WORD_BITS-1:0] end_b_x;
    logic signed [WORD_BITS-1:0] end_b_y;
    logic signed [WORD_BITS-1:0] vel_a_x;
    logic signed [WORD_BITS-1:0] vel_a_y;
    logic signed [WORD_BITS-1:0] vel_b_x;
    logic signed [WORD_BITS-1:0] vel_b_y;
  } item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] impulse_x;
    logic signed [WORD_BITS-1:0] impulse_y;
    logic                        was_clamped;
    logic                        zero_span;
  } res_t;

  typedef struct packed {
    logic [REG_BITS-1:0] stiff;
    logic [REG_BITS-1:0] damp;
    logic [REG_BITS-1:0] nat;
    logic [REG_BITS-1:0] step;
    logic [REG_BITS-1:0] ceil;
  } cfg_t;

  typedef struct packed {
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic signed [63:0] rvx;
    logic signed [63:0] rvy;
    logic               zero;
  } entry_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_e;

  typedef struct packed {
    logic          start;
    alu_op_e       op;
    logic [63:0]   a;
    logic [63:0]   b;
    logic [127:0]  n;
  } alu_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [127:0]  res;
  } alu_rsp_t;

  function automatic logic signed [63:0] sx(input logic [WORD_BITS-1:0] v);
    return {{(64-WORD_BITS){v[WORD_BITS-1]}}, v};
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic signed [63:0] apply_sign(input logic [63:0] m, input logic neg);
    logic [63:0] c;
    c = m[63] ? S64_MAX : m;
    return neg ? -c : c;
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] d;
    d = {a[63], a} - {b[63], b};
    if (d[64] != d[63]) return d[64] ? S64_MIN : S64_MAX;
    return d[63:0];
  endfunction

  function automatic logic signed [63:0] mul_shift(input logic [127:0] p, input int sh,
                                                   input logic neg);
    logic [127:0] t;
    t = p >> sh;
    return apply_sign((t[127:64] != 64'd0) ? S64_MAX : t[63:0], neg);
  endfunction

  function automatic logic signed [WORD_BITS-1:0] out_word(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (WORD_BITS-1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[WORD_BITS-1:0];
    if (v < lo) return lo[WORD_BITS-1:0];
    return v[WORD_BITS-1:0];
  endfunction

endpackage

[src/sdi_front.sv]
// ----------------------------------------------------------------------------
// sdi_front
// Accepts items, forms position and velocity differences, flags zero span.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdi_front (
  input  logic           start_i,
  input  sdi_pkg::item_t item_i,
  input  logic           full_i,
  output logic           busy_o,
  output logic           push_o,
  output sdi_pkg::entry_t entry_o
);

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  always_comb begin
    entry_o.dx   = sdi_pkg::sat_sub(sdi_pkg::sx(item_i.end_b_x), sdi_pkg::sx(item_i.end_a_x));
    entry_o.dy   = sdi_pkg::sat_sub(sdi_pkg::sx(item_i.end_b_y), sdi_pkg::sx(item_i.end_a_y));
    entry_o.rvx  = sdi_pkg::sat_sub(sdi_pkg::sx(item_i.vel_b_x), sdi_pkg::sx(item_i.vel_a_x));
    entry_o.rvy  = sdi_pkg::sat_sub(sdi_pkg::sx(item_i.vel_b_y), sdi_pkg::sx(item_i.vel_a_y));
    // length is zero exactly when both differences are zero
    entry_o.zero = (entry_o.dx == 64'sd0) && (entry_o.dy == 64'sd0);
  end

endmodule

[src/sdi_fifo.sv]
// ----------------------------------------------------------------------------
// sdi_fifo
// Short item queue between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdi_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sdi_pkg::entry_t entry_i,
  input  logic            pop_i,
  output sdi_pkg::entry_t entry_o,
  output logic            empty_o,
  output logic            full_o
);

  sdi_pkg::entry_t mem_q [sdi_pkg::QDEPTH];
  logic [sdi_pkg::QPTR_BITS-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [sdi_pkg::QPTR_BITS:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (sdi_pkg::QPTR_BITS+1)'(sdi_pkg::QDEPTH));
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q + (sdi_pkg::QPTR_BITS)'(push_i);
    rd_d  = rd_q + (sdi_pkg::QPTR_BITS)'(pop_i);
    cnt_d = cnt_q + (sdi_pkg::QPTR_BITS+1)'(push_i) - (sdi_pkg::QPTR_BITS+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

[src/sdi_alu.sv]
// ----------------------------------------------------------------------------
// sdi_alu
// Serial unit: 64x64 shift-add multiply, 128/64 restoring divide, 128-bit
// digit-by-digit square root. One bit (root: one digit) per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdi_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdi_pkg::alu_req_t req_i,
  output sdi_pkg::alu_rsp_t rsp_o
);

  logic             busy_q, done_q;
  sdi_pkg::alu_op_e op_q;
  logic [6:0]       cnt_q;
  logic [127:0]     wa_q, wa_d;
  logic [127:0]     wb_q, wb_d;
  logic [66:0]      r_q, r_d;
  logic [63:0]      q_q, q_d;

  logic [63:0] rr;
  logic        carry;
  logic [66:0] rem;
  logic [66:0] trial;

  always_comb begin
    wa_d  = wa_q;
    wb_d  = wb_q;
    r_d   = r_q;
    q_d   = q_q;
    rr    = {r_q[62:0], wa_q[127]};
    carry = r_q[63];
    rem   = {r_q[64:0], wa_q[127:126]};
    trial = {1'b0, q_q, 2'b01};
    case (op_q)
      sdi_pkg::ALU_MUL: begin
        if (q_q[0]) wb_d = wb_q + wa_q;
        wa_d = wa_q << 1;
        q_d  = q_q >> 1;
      end
      sdi_pkg::ALU_DIV: begin
        wa_d = wa_q << 1;
        q_d  = q_q << 1;
        // with the carry set the partial remainder is at least 2^64 > divisor
        if (carry || rr >= wb_q[63:0]) begin
          rr     = rr - wb_q[63:0];
          q_d[0] = 1'b1;
        end
        r_d = {3'b000, rr};
      end
      sdi_pkg::ALU_SQRT: begin
        wa_d = wa_q << 2;
        if (rem >= trial) begin
          r_d = rem - trial;
          q_d = {q_q[62:0], 1'b1};
        end else begin
          r_d = rem;
          q_d = {q_q[62:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= sdi_pkg::ALU_MUL;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= (req_i.op == sdi_pkg::ALU_DIV) ? 7'd127 : 7'd63;
      end else if (busy_q) begin
        if (cnt_q == 7'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      r_q <= '0;
      case (req_i.op)
        sdi_pkg::ALU_MUL: begin
          wa_q <= {64'd0, req_i.a};
          wb_q <= '0;
          q_q  <= req_i.b;
        end
        default: begin
          wa_q <= req_i.n;
          wb_q <= {64'd0, req_i.b};
          q_q  <= '0;
        end
      endcase
    end else if (busy_q) begin
      wa_q <= wa_d;
      wb_q <= wb_d;
      r_q  <= r_d;
      q_q  <= q_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = (op_q == sdi_pkg::ALU_MUL) ? wb_q : {64'd0, q_q};

endmodule

[src/sdi_back.sv]
// ----------------------------------------------------------------------------
// sdi_back
// Sequencer that carries one queued item through the serial unit and
// delivers the impulse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spring_damper_impulse_core_defines.svh"

module sdi_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdi_pkg::cfg_t     cfg_i,
  input  logic              empty_i,
  input  sdi_pkg::entry_t   entry_i,
  output logic              pop_o,
  output sdi_pkg::alu_req_t req_o,
  input  sdi_pkg::alu_rsp_t rsp_i,
  output logic              valid_o,
  output sdi_pkg::res_t     res_o
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SQX  = 5'd1;
  localparam logic [4:0] ST_SQY  = 5'd2;
  localparam logic [4:0] ST_LEN  = 5'd3;
  localparam logic [4:0] ST_DIRX = 5'd4;
  localparam logic [4:0] ST_DIRY = 5'd5;
  localparam logic [4:0] ST_S    = 5'd6;
  localparam logic [4:0] ST_SPX  = 5'd7;
  localparam logic [4:0] ST_DMX  = 5'd8;
  localparam logic [4:0] ST_SPY  = 5'd9;
  localparam logic [4:0] ST_DMY  = 5'd10;
  localparam logic [4:0] ST_FSX  = 5'd11;
  localparam logic [4:0] ST_FSY  = 5'd12;
  localparam logic [4:0] ST_MAG  = 5'd13;
  localparam logic [4:0] ST_CMX  = 5'd14;
  localparam logic [4:0] ST_CDX  = 5'd15;
  localparam logic [4:0] ST_CMY  = 5'd16;
  localparam logic [4:0] ST_CDY  = 5'd17;
  localparam logic [4:0] ST_IMX  = 5'd18;
  localparam logic [4:0] ST_IMY  = 5'd19;

  logic [4:0]         state_q, state_d;
  logic               wait_q;
  sdi_pkg::entry_t    ent_q;
  logic [127:0]       sq_q;
  logic [63:0]        len_q, mag_q;
  logic signed [63:0] dirx_q, diry_q, s_q, sp_q, fx_q, fy_q;
  logic               clamp_q;
  logic               valid_q;
  sdi_pkg::res_t      res_q;

  logic signed [63:0] stretch;
  logic [63:0]        stiff_w, damp_w, nat_w, step_w, ceil_w;

  function automatic logic mag_d_gt_ceil(input logic [63:0] m);
    return m > ceil_w;
  endfunction

  assign stiff_w = {33'd0, cfg_i.stiff};
  assign damp_w  = {33'd0, cfg_i.damp};
  assign nat_w   = {33'd0, cfg_i.nat};
  assign step_w  = {33'd0, cfg_i.step};
  assign ceil_w  = {33'd0, cfg_i.ceil};
  assign stretch = sdi_pkg::sat_sub(nat_w, sdi_pkg::apply_sign(len_q, 1'b0));

  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  always_comb begin
    req_o.start = (state_q != ST_IDLE) && !wait_q;
    req_o.op    = sdi_pkg::ALU_MUL;
    req_o.a     = '0;
    req_o.b     = '0;
    req_o.n     = '0;
    case (state_q)
      ST_SQX: begin
        req_o.a = sdi_pkg::mag64(ent_q.dx);
        req_o.b = sdi_pkg::mag64(ent_q.dx);
      end
      ST_SQY: begin
        req_o.a = sdi_pkg::mag64(ent_q.dy);
        req_o.b = sdi_pkg::mag64(ent_q.dy);
      end
      ST_LEN, ST_MAG: begin
        req_o.op = sdi_pkg::ALU_SQRT;
        req_o.n  = sq_q;
      end
      ST_DIRX: begin
        req_o.op = sdi_pkg::ALU_DIV;
        req_o.n  = {64'd0, sdi_pkg::mag64(ent_q.dx)} << sdi_pkg::DIR_BITS;
        req_o.b  = len_q;
      end
      ST_DIRY: begin
        req_o.op = sdi_pkg::ALU_DIV;
        req_o.n  = {64'd0, sdi_pkg::mag64(ent_q.dy)} << sdi_pkg::DIR_BITS;
        req_o.b  = len_q;
      end
      ST_S: begin
        req_o.a = stiff_w;
        req_o.b = sdi_pkg::mag64(stretch);
      end
      ST_SPX: begin
        req_o.a = sdi_pkg::mag64(s_q);
        req_o.b = sdi_pkg::mag64(dirx_q);
      end
      ST_SPY: begin
        req_o.a = sdi_pkg::mag64(s_q);
        req_o.b = sdi_pkg::mag64(diry_q);
      end
      ST_DMX: begin
        req_o.a = damp_w;
        req_o.b = sdi_pkg::mag64(ent_q.rvx);
      end
      ST_DMY: begin
        req_o.a = damp_w;
        req_o.b = sdi_pkg::mag64(ent_q.rvy);
      end
      ST_FSX: begin
        req_o.a = sdi_pkg::mag64(fx_q);
        req_o.b = sdi_pkg::mag64(fx_q);
      end
      ST_FSY: begin
        req_o.a = sdi_pkg::mag64(fy_q);
        req_o.b = sdi_pkg::mag64(fy_q);
      end
      ST_CMX: begin
        req_o.a = sdi_pkg::mag64(fx_q);
        req_o.b = ceil_w;
      end
      ST_CMY: begin
        req_o.a = sdi_pkg::mag64(fy_q);
        req_o.b = ceil_w;
      end
      ST_CDX, ST_CDY: begin
        req_o.op = sdi_pkg::ALU_DIV;
        req_o.n  = sq_q;
        req_o.b  = mag_q;
      end
      ST_IMX: begin
        req_o.a = sdi_pkg::mag64(fx_q);
        req_o.b = step_w;
      end
      ST_IMY: begin
        req_o.a = sdi_pkg::mag64(fy_q);
        req_o.b = step_w;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    if (state_q == ST_IDLE) begin
      if (!empty_i) state_d = ST_SQX;
    end else if (rsp_i.done) begin
      case (state_q)
        ST_LEN:  state_d = ent_q.zero ? ST_S : ST_DIRX;
        ST_MAG:  state_d = (mag_d_gt_ceil(rsp_i.res[63:0])) ? ST_CMX : ST_IMX;
        ST_CDY:  state_d = ST_IMX;
        ST_IMY:  state_d = ST_IDLE;
        default: state_d = state_q + 5'd1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wait_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == ST_IMY) && rsp_i.done;
      if (rsp_i.done)       wait_q <= 1'b0;
      else if (req_o.start) wait_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= entry_i;
    end
    if (rsp_i.done) begin
      case (state_q)
        ST_SQX, ST_FSX, ST_CMX, ST_CMY: sq_q <= rsp_i.res;
        ST_SQY, ST_FSY: sq_q <= sq_q + rsp_i.res;
        ST_LEN: begin
          len_q  <= rsp_i.res[63:0];
          dirx_q <= '0;
          diry_q <= '0;
        end
        ST_DIRX: dirx_q <= sdi_pkg::apply_sign(rsp_i.res[63:0], ent_q.dx[63]);
        ST_DIRY: diry_q <= sdi_pkg::apply_sign(rsp_i.res[63:0], ent_q.dy[63]);
        ST_S:    s_q <= sdi_pkg::mul_shift(rsp_i.res, sdi_pkg::FRAC_BITS, stretch[63]);
        ST_SPX:  sp_q <= sdi_pkg::mul_shift(rsp_i.res, sdi_pkg::DIR_BITS,
                                            s_q[63] != dirx_q[63]);
        ST_SPY:  sp_q <= sdi_pkg::mul_shift(rsp_i.res, sdi_pkg::DIR_BITS,
                                            s_q[63] != diry_q[63]);
        ST_DMX:  fx_q <= sdi_pkg::sat_sub(sp_q,
                   sdi_pkg::mul_shift(rsp_i.res, sdi_pkg::FRAC_BITS, ent_q.rvx[63]));
        ST_DMY:  fy_q <= sdi_pkg::sat_sub(sp_q,
                   sdi_pkg::mul_shift(rsp_i.res, sdi_pkg::FRAC_BITS, ent_q.rvy[63]));
        ST_MAG: begin
          mag_q   <= rsp_i.res[63:0];
          clamp_q <= mag_d_gt_ceil(rsp_i.res[63:0]);
        end
        ST_CDX:  fx_q <= sdi_pkg::apply_sign(rsp_i.res[63:0], fx_q[63]);
        ST_CDY:  fy_q <= sdi_pkg::apply_sign(rsp_i.res[63:0], fy_q[63]);
        ST_IMX:  res_q.impulse_x <= sdi_pkg::out_word(
                   sdi_pkg::mul_shift(rsp_i.res, sdi_pkg::FRAC_BITS, fx_q[63]));
        ST_IMY: begin
          res_q.impulse_y   <= sdi_pkg::out_word(
                                 sdi_pkg::mul_shift(rsp_i.res, sdi_pkg::FRAC_BITS, fy_q[63]));
          res_q.was_clamped <= clamp_q;
          res_q.zero_span   <= ent_q.zero;
        end
        default: begin
        end
      endcase
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  `SDI_ASSERT(a_start_idle_alu, req_o.start |-> !rsp_i.busy, "op issued while unit busy")
  `SDI_ASSERT(a_done_expected, rsp_i.done |-> wait_q, "unit done without pending op")
  `SDI_ASSERT(a_valid_after_imy, valid_q |-> ($past(state_q) == ST_IMY), "stray result")

endmodule

[src/spring_damper_impulse_core.sv]
// Spring damper impulse core: items are queued (depth 4) and computed one at a
// time by a bit-serial unit. New items are accepted into the queue while one is
// computed, until the queue is full. Reset clears the queue, sequencer and
// registers to their defaults. Results are a one-cycle strobe; the receiver
// cannot stall.
// ----------------------------------------------------------------------------
// spring_damper_impulse_core
// Top level: config registers, front, item queue, back and serial unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spring_damper_impulse_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  sdi_pkg::item_t                      item_i,
  output logic                                result_valid_o,
  output sdi_pkg::res_t                       result_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sdi_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [sdi_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

  sdi_pkg::cfg_t     cfg_q;
  sdi_pkg::entry_t   push_entry, head_entry;
  logic              push, pop, empty, full;
  sdi_pkg::alu_req_t alu_req;
  sdi_pkg::alu_rsp_t alu_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stiff <= '0;
      cfg_q.damp  <= '0;
      cfg_q.nat   <= '0;
      cfg_q.step  <= sdi_pkg::STEP_RESET;
      cfg_q.ceil  <= sdi_pkg::CEILING_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sdi_pkg::REG_STIFF: cfg_q.stiff <= cfg_data_i[sdi_pkg::REG_BITS-1:0];
        sdi_pkg::REG_DAMP:  cfg_q.damp  <= cfg_data_i[sdi_pkg::REG_BITS-1:0];
        sdi_pkg::REG_NAT:   cfg_q.nat   <= cfg_data_i[sdi_pkg::REG_BITS-1:0];
        sdi_pkg::REG_STEP:  cfg_q.step  <= cfg_data_i[sdi_pkg::REG_BITS-1:0];
        sdi_pkg::REG_CEIL:  cfg_q.ceil  <= cfg_data_i[sdi_pkg::REG_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  sdi_front u_front (
    .start_i (start_i),
    .item_i  (item_i),
    .full_i  (full),
    .busy_o  (busy_o),
    .push_o  (push),
    .entry_o (push_entry)
  );

  sdi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (empty),
    .full_o  (full)
  );

  sdi_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  sdi_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .entry_i (head_entry),
    .pop_o   (pop),
    .req_o   (alu_req),
    .rsp_i   (alu_rsp),
    .valid_o (result_valid_o),
    .res_o   (result_o)
  );

endmodule
